// ----- src/sorted_key_table_insert_defines.svh -----
// Assertion macros used by the sorted key table datapath module.
`ifndef SORTED_KEY_TABLE_INSERT_DEFINES_SVH
`define SORTED_KEY_TABLE_INSERT_DEFINES_SVH

`ifndef NO_ASSERTIONS
`define SKTI_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
`define SKTI_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`define SKTI_ASSERT_NEVER(label, clk, rst_n, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error("assertion failed");
`else
`define SKTI_ASSERT_IMPLY(label, clk, rst_n, ante, cons)
`define SKTI_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`define SKTI_ASSERT_NEVER(label, clk, rst_n, cond)
`endif

`endif

// ----- src/skti_pkg.sv -----
`timescale 1ns / 1ps

package skti_pkg;

    localparam int KEY_W = 32;

    localparam logic OP_INSERT = 1'b0;
    localparam logic OP_READ   = 1'b1;

    localparam logic [2:0] ST_INSERTED  = 3'd0;
    localparam logic [2:0] ST_DUPLICATE = 3'd1;
    localparam logic [2:0] ST_FULL      = 3'd2;
    localparam logic [2:0] ST_READ_OK   = 3'd3;
    localparam logic [2:0] ST_READ_OOR  = 3'd4;

    typedef struct packed {
        logic              operation;
        logic signed [31:0] key;
        logic [31:0]       name_tag;
        logic [5:0]        read_index;
    } in_item_t;

    typedef struct packed {
        logic [2:0]        status;
        logic [5:0]        position;
        logic signed [31:0] key_out;
        logic [31:0]       tag_out;
        logic [6:0]        entry_total;
    } out_item_t;

    typedef struct packed {
        logic       load;
        logic       init_search;
        logic       probe_rd;
        logic       probe_upd;
        logic       shift_init;
        logic       shift_rd;
        logic       shift_wr;
        logic       ins_wr;
        logic       rd_issue;
        logic       out_load;
        logic [2:0] res_status;
    } cmd_t;

    typedef struct packed {
        logic op_read;
        logic full;
        logic idx_ok;
        logic search_done;
        logic dup;
        logic no_shift;
        logic shift_last;
        logic out_free;
    } sts_t;

endpackage

// ----- src/skti_ram.sv -----
`timescale 1ns / 1ps

module skti_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

// ----- src/skti_ctrl.sv -----
`timescale 1ns / 1ps

module skti_ctrl (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           s_valid,
    output logic           s_ready,
    input  skti_pkg::sts_t sts,
    output skti_pkg::cmd_t cmd
);

    import skti_pkg::*;

    localparam logic [2:0] S_IDLE      = 3'd0;
    localparam logic [2:0] S_DISPATCH  = 3'd1;
    localparam logic [2:0] S_PROBE_RD  = 3'd2;
    localparam logic [2:0] S_PROBE_CMP = 3'd3;
    localparam logic [2:0] S_SHIFT_RD  = 3'd4;
    localparam logic [2:0] S_SHIFT_WR  = 3'd5;
    localparam logic [2:0] S_INSERT    = 3'd6;
    localparam logic [2:0] S_RESP      = 3'd7;

    logic [2:0] state_reg, state_next;
    logic [2:0] res_reg, res_next;

    assign s_ready = (state_reg == S_IDLE);

    always_comb begin
        state_next   = state_reg;
        res_next     = res_reg;
        cmd          = '0;
        cmd.res_status = res_reg;
        case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    cmd.load   = 1'b1;
                    state_next = S_DISPATCH;
                end
            end
            S_DISPATCH: begin
                if (sts.op_read) begin
                    if (sts.idx_ok) begin
                        cmd.rd_issue = 1'b1;
                        res_next     = ST_READ_OK;
                    end else begin
                        res_next = ST_READ_OOR;
                    end
                    state_next = S_RESP;
                end else if (sts.full) begin
                    res_next   = ST_FULL;
                    state_next = S_RESP;
                end else begin
                    cmd.init_search = 1'b1;
                    state_next      = S_PROBE_RD;
                end
            end
            S_PROBE_RD: begin
                if (sts.search_done) begin
                    if (sts.dup) begin
                        res_next   = ST_DUPLICATE;
                        state_next = S_RESP;
                    end else if (sts.no_shift) begin
                        state_next = S_INSERT;
                    end else begin
                        cmd.shift_init = 1'b1;
                        state_next     = S_SHIFT_RD;
                    end
                end else begin
                    cmd.probe_rd = 1'b1;
                    state_next   = S_PROBE_CMP;
                end
            end
            S_PROBE_CMP: begin
                cmd.probe_upd = 1'b1;
                state_next    = S_PROBE_RD;
            end
            S_SHIFT_RD: begin
                cmd.shift_rd = 1'b1;
                state_next   = S_SHIFT_WR;
            end
            S_SHIFT_WR: begin
                cmd.shift_wr = 1'b1;
                state_next   = sts.shift_last ? S_INSERT : S_SHIFT_RD;
            end
            S_INSERT: begin
                cmd.ins_wr = 1'b1;
                res_next   = ST_INSERTED;
                state_next = S_RESP;
            end
            S_RESP: begin
                if (sts.out_free) begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            res_reg     <= ST_INSERTED;
        end else begin
            state_reg   <= state_next;
            res_reg     <= res_next;
        end
    end

endmodule

// ----- src/skti_dpath.sv -----
`timescale 1ns / 1ps

`include "sorted_key_table_insert_defines.svh"

module skti_dpath #(
    parameter int CAPACITY  = 64,
    parameter int TAG_WIDTH = 32
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  skti_pkg::in_item_t  s_payload,
    output logic                m_valid,
    input  logic                m_ready,
    output skti_pkg::out_item_t m_payload,
    input  skti_pkg::cmd_t      cmd,
    output skti_pkg::sts_t      sts
);

    import skti_pkg::*;

    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam int IDX_W = $clog2(CAPACITY);
    localparam int ENT_W = KEY_W + TAG_WIDTH;

    logic                 op_reg;
    logic [KEY_W-1:0]     key_reg;
    logic [TAG_WIDTH-1:0] tag_reg;
    logic [5:0]           idx_reg;
    logic [CNT_W-1:0]     count_reg;
    logic [CNT_W-1:0]     lo_reg;
    logic [CNT_W-1:0]     hi_reg;
    logic                 dup_reg;
    logic [IDX_W-1:0]     j_reg;
    logic                 m_valid_reg;
    out_item_t            m_payload_reg;

    logic [CNT_W:0]       mid_sum;
    logic [CNT_W-1:0]     mid;
    logic [63:0]          tag_in_ext;
    logic [31:0]          idx_ext;
    logic [31:0]          cnt_ext;
    logic [31:0]          lo_ext;
    logic [KEY_W-1:0]     rd_key;
    logic [TAG_WIDTH-1:0] rd_tag;
    logic [63:0]          rd_tag_ext;
    logic                 ram_we;
    logic [IDX_W-1:0]     ram_waddr;
    logic [ENT_W-1:0]     ram_wdata;
    logic                 ram_re;
    logic [IDX_W-1:0]     ram_raddr;
    logic [ENT_W-1:0]     ram_rdata;
    logic                 key_less;
    logic                 key_equal;
    out_item_t            result;

    assign mid_sum    = {1'b0, lo_reg} + {1'b0, hi_reg};
    assign mid        = mid_sum[CNT_W:1];
    assign tag_in_ext = 64'(s_payload.name_tag);
    assign idx_ext    = 32'(idx_reg);
    assign cnt_ext    = 32'(count_reg);
    assign lo_ext     = 32'(lo_reg);
    assign rd_key     = ram_rdata[ENT_W-1:TAG_WIDTH];
    assign rd_tag     = ram_rdata[TAG_WIDTH-1:0];
    assign rd_tag_ext = 64'(rd_tag);
    assign key_less   = $signed(rd_key) < $signed(key_reg);
    assign key_equal  = (rd_key == key_reg);

    assign sts.op_read     = (op_reg == OP_READ);
    assign sts.full        = (cnt_ext >= 32'(CAPACITY));
    assign sts.idx_ok      = (idx_ext < cnt_ext);
    assign sts.search_done = (lo_reg == hi_reg);
    assign sts.dup         = dup_reg;
    assign sts.no_shift    = (lo_reg == count_reg);
    assign sts.shift_last  = (j_reg == lo_reg[IDX_W-1:0]);
    assign sts.out_free    = !m_valid_reg || m_ready;

    always_comb begin
        ram_re    = cmd.probe_rd || cmd.shift_rd || cmd.rd_issue;
        ram_raddr = idx_ext[IDX_W-1:0];
        if (cmd.probe_rd) begin
            ram_raddr = mid[IDX_W-1:0];
        end else if (cmd.shift_rd) begin
            ram_raddr = j_reg;
        end
        ram_we    = cmd.shift_wr || cmd.ins_wr;
        ram_waddr = lo_reg[IDX_W-1:0];
        ram_wdata = {key_reg, tag_reg};
        if (cmd.shift_wr) begin
            ram_waddr = j_reg + IDX_W'(1);
            ram_wdata = ram_rdata;
        end
    end

    skti_ram #(
        .WIDTH (ENT_W),
        .DEPTH (CAPACITY)
    ) u_ram (
        .clk     (aclk),
        .wr_en   (ram_we),
        .wr_addr (ram_waddr),
        .wr_data (ram_wdata),
        .rd_en   (ram_re),
        .rd_addr (ram_raddr),
        .rd_data (ram_rdata)
    );

    always_comb begin
        result             = '0;
        result.status      = cmd.res_status;
        result.entry_total = cnt_ext[6:0];
        case (cmd.res_status)
            ST_INSERTED: begin
                result.position = lo_ext[5:0];
            end
            ST_READ_OK: begin
                result.position = idx_reg;
                result.key_out  = rd_key;
                result.tag_out  = rd_tag_ext[31:0];
            end
            ST_READ_OOR: begin
                result.position = idx_reg;
            end
            default: begin
                result.position = '0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            op_reg  <= s_payload.operation;
            key_reg <= s_payload.key;
            tag_reg <= tag_in_ext[TAG_WIDTH-1:0];
            idx_reg <= s_payload.read_index;
        end
        if (cmd.init_search) begin
            lo_reg  <= '0;
            hi_reg  <= count_reg;
            dup_reg <= 1'b0;
        end else if (cmd.probe_upd) begin
            if (key_less) begin
                lo_reg <= mid + CNT_W'(1);
            end else begin
                hi_reg <= mid;
            end
            if (key_equal) begin
                dup_reg <= 1'b1;
            end
        end
        if (cmd.shift_init) begin
            j_reg <= IDX_W'(cnt_ext - 32'd1);
        end else if (cmd.shift_wr) begin
            j_reg <= j_reg - IDX_W'(1);
        end
        if (cmd.out_load) begin
            m_payload_reg <= result;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            if (cmd.ins_wr) begin
                count_reg <= count_reg + CNT_W'(1);
            end
            if (cmd.out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    assign m_valid   = m_valid_reg;
    assign m_payload = m_payload_reg;

    `SKTI_ASSERT_NEVER(a_count_bound, aclk, aresetn, cnt_ext > 32'(CAPACITY))
    `SKTI_ASSERT_IMPLY(a_ins_not_full, aclk, aresetn, cmd.ins_wr, !sts.full && !dup_reg)
    `SKTI_ASSERT_NEXT(a_ins_count, aclk, aresetn, cmd.ins_wr, count_reg == $past(count_reg) + CNT_W'(1))
    `SKTI_ASSERT_IMPLY(a_out_room, aclk, aresetn, cmd.out_load, !m_valid_reg || m_ready)

endmodule

// ----- src/sorted_key_table_insert.sv -----
`timescale 1ns / 1ps

// Sorted table of unique signed keys, each stored with a tag.
// Input beats on s_valid/s_ready carry an operation: insert a key with its tag,
// or read the entry at read_index. Each input beat gives exactly one result beat
// on m_valid/m_ready with a status, the position, the key and tag read, and the
// entry count after the operation.
// One operation is in the block at a time; s_ready is high only while it is idle,
// so the next beat can be taken in the cycle after the result register loads.
// A read goes from acceptance through the dispatch state, which reads the table
// memory, to the response state, which loads the result register. An insert runs
// a binary search, a probe read and a compare state per probe, then moves each
// higher entry one place up, a read and a write state per entry, through the one
// memory read port. A full table ends at once, a duplicate key after the search.
// After reset the table is empty; memory contents need no clearing.
// If the receiver stalls, the result waits in the output register and the block
// holds its finished operation until the register frees, then takes the next beat.

module sorted_key_table_insert #(
    parameter int CAPACITY  = 64,
    parameter int TAG_WIDTH = 32
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  skti_pkg::in_item_t  s_payload,
    output logic                m_valid,
    input  logic                m_ready,
    output skti_pkg::out_item_t m_payload
);

    import skti_pkg::*;

    cmd_t cmd;
    sts_t sts;

    skti_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .sts     (sts),
        .cmd     (cmd)
    );

    skti_dpath #(
        .CAPACITY  (CAPACITY),
        .TAG_WIDTH (TAG_WIDTH)
    ) u_dpath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_payload (s_payload),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_payload (m_payload),
        .cmd       (cmd),
        .sts       (sts)
    );

endmodule
